// ===== design/pixel_to_ground_position_unit_assert.svh =====
// Assertion macros shared by the checker of the pixel to ground position unit.
// Each macro expects a signal named clock, and all but P2G_ASSERT_RAW one named reset, in the scope where it is used.
`ifndef PIXEL_TO_GROUND_POSITION_UNIT_ASSERT_SVH
`define PIXEL_TO_GROUND_POSITION_UNIT_ASSERT_SVH

// Consequent checked in the cycle after the antecedent, outside reset.
`define P2G_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("p2g: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent, outside reset.
`define P2G_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("p2g: same-cycle check failed");

// Next-cycle check that stays active while reset is high.
`define P2G_ASSERT_RAW(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("p2g: reset check failed");

`endif

// ===== design/p2g_pkg.sv =====
// ----------------------------------------------------------------------------
// p2g_pkg
// Types, register codes and constants of the pixel to ground position unit.
// ----------------------------------------------------------------------------
package p2g_pkg;

   localparam int ANG_W = 24;           // angle: 2^24 units per half turn
   localparam int ROT_Z_W = 26;
   localparam int TAN_W = 32;
   localparam int QUO_BITS = 31;        // quotient bits below the overflow limit
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOCAL      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAM_HEIGHT = 3'd4;

   // Pitch in 1/256 degree to angle units: divide by 45 through a reciprocal.
   localparam logic [30:0] PITCH_RECIP = 31'd1527099484;
   localparam int PITCH_SHIFT = 36;
   localparam logic [29:0] PITCH_BIAS = 30'd22;

   localparam logic signed [TAN_W-1:0] TAN_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [13:0]        focal_length_px;
      logic [13:0]        image_width;
      logic [13:0]        image_height;
      logic signed [15:0] pitch_angle;
      logic [15:0]        camera_height_mm;
   } p2g_cfg_type;

   // atan(2^-i) in units of 2^-24 half turn.
   function automatic logic [ANG_W-1:0] atan_step(input int unsigned i);
      logic [ANG_W-1:0] v;
      case (i)
         0:  v = 24'd4194304;
         1:  v = 24'd2476042;
         2:  v = 24'd1308273;
         3:  v = 24'd664100;
         4:  v = 24'd333339;
         5:  v = 24'd166832;
         6:  v = 24'd83436;
         7:  v = 24'd41721;
         8:  v = 24'd20861;
         9:  v = 24'd10430;
         10: v = 24'd5215;
         11: v = 24'd2608;
         12: v = 24'd1304;
         13: v = 24'd652;
         14: v = 24'd326;
         15: v = 24'd163;
         16: v = 24'd81;
         17: v = 24'd41;
         18: v = 24'd20;
         19: v = 24'd10;
         20: v = 24'd5;
         21: v = 24'd3;
         22: v = 24'd1;
         23: v = 24'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/p2g_stream_if.sv =====
// ----------------------------------------------------------------------------
// p2g_req_if / p2g_rsp_if
// Valid/ready channels for pixel words in and ground position words out.
// ----------------------------------------------------------------------------
interface p2g_req_if #(parameter int COORD_BITS = 13);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface p2g_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] forward_mm;
   logic signed [31:0] lateral_mm;
   logic               saturated;

   modport source (output valid, output forward_mm, output lateral_mm, output saturated,
                   input ready);
   modport sink (input valid, input forward_mm, input lateral_mm, input saturated,
                 output ready);
endinterface

// ===== design/pixel_to_ground_position_unit.sv =====
// From an accepted pixel word to its result word: angle stages, queue, rotation stages,
// a 32-stage divider, the multiply stages. Throughput: one word per cycle unless the output
// stalls; every stage is pipelined and the queue decouples the halves.
// Reset: synchronous, active high; empties the pipeline and queue and loads register defaults.
// ----------------------------------------------------------------------------
// pixel_to_ground_position_unit
// Projects a pixel onto flat ground with a pinhole camera model.
// ----------------------------------------------------------------------------
module pixel_to_ground_position_unit #(
   parameter int COORD_BITS = 13,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   p2g_req_if.sink                             req,
   p2g_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [p2g_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [p2g_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import p2g_pkg::*;

   localparam int OFS_BITS = (COORD_BITS + 2 > 15) ? COORD_BITS + 2 : 15;
   localparam int QW = ANG_W + OFS_BITS;

   p2g_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_length_px  <= 14'd1000;
         cfg_ff.image_width      <= 14'd640;
         cfg_ff.image_height     <= 14'd480;
         cfg_ff.pitch_angle      <= '0;
         cfg_ff.camera_height_mm <= 16'd1000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FOCAL:      cfg_ff.focal_length_px  <= csr_wdata[13:0];
            CSR_WIDTH:      cfg_ff.image_width      <= csr_wdata[13:0];
            CSR_HEIGHT:     cfg_ff.image_height     <= csr_wdata[13:0];
            CSR_PITCH:      cfg_ff.pitch_angle      <= $signed(csr_wdata);
            CSR_CAM_HEIGHT: cfg_ff.camera_height_mm <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                       f_valid;
   logic [ANG_W-1:0]           f_angle;
   logic signed [OFS_BITS-1:0] f_dx;
   logic                       q_space;
   logic                       h_valid;
   logic [QW-1:0]              h_data;
   logic                       b_pull;

   p2g_front #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS), .OFS_BITS(OFS_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req),
      .out_valid (f_valid),
      .out_angle (f_angle),
      .out_dx    (f_dx),
      .out_ready (q_space)
   );

   p2g_queue #(.W(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_data    ({f_angle, f_dx}),
      .in_space   (q_space),
      .head_valid (h_valid),
      .head_data  (h_data),
      .pull       (b_pull)
   );

   p2g_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS), .OFS_BITS(OFS_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (h_valid),
      .head_angle (h_data[QW-1:OFS_BITS]),
      .head_dx    ($signed(h_data[OFS_BITS-1:0])),
      .pull       (b_pull),
      .rsp        (rsp)
   );

endmodule

// ===== design/p2g_divider.sv =====
// ----------------------------------------------------------------------------
// p2g_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module p2g_divider #(
   parameter int NB = 49,
   parameter int DB = 33,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NB-1:0] num,
   input  logic [DB-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [p2g_pkg::QUO_BITS-1:0] quo,
   output logic          ovf,
   output logic [SW-1:0] side_out
);
   import p2g_pkg::*;

   localparam int QB = QUO_BITS;
   localparam int CW = ((NB > DB + QB) ? NB : DB + QB) + 1;

   logic          v_ff    [0:QB];
   logic [NB-1:0] r_ff    [0:QB];
   logic [DB-1:0] d_ff    [0:QB];
   logic [QB-1:0] q_ff    [0:QB];
   logic          ovf_ff  [0:QB];
   logic [SW-1:0] side_ff [0:QB];

   // The quotient is at least 2^QB exactly when num >= den * 2^QB.
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= num;
         d_ff[0]    <= den;
         q_ff[0]    <= '0;
         ovf_ff[0]  <= CW'(num) >= (CW'(den) << QB);
         side_ff[0] <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QB; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= QB; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   for (genvar s = 1; s <= QB; s++) begin : g_stage
      localparam int K = QB - s;
      logic [CW-1:0] trial;
      logic          take;
      logic [NB-1:0] r_in;
      logic [QB-1:0] q_in;

      always_comb begin
         trial = CW'(d_ff[s-1]) << K;
         take  = CW'(r_ff[s-1]) >= trial;
         r_in  = take ? NB'(CW'(r_ff[s-1]) - trial) : r_ff[s-1];
         q_in  = q_ff[s-1];
         q_in[K] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]    <= r_in;
            d_ff[s]    <= d_ff[s-1];
            q_ff[s]    <= q_in;
            ovf_ff[s]  <= ovf_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign quo       = q_ff[QB];
   assign ovf       = ovf_ff[QB];
   assign side_out  = side_ff[QB];

endmodule

// ===== design/p2g_front.sv =====
// ----------------------------------------------------------------------------
// p2g_front
// Takes pixel words, forms image-centre offsets and the total view angle.
// ----------------------------------------------------------------------------
module p2g_front #(
   parameter int ANGLE_ITERATIONS = 16,
   parameter int OFS_BITS = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  p2g_pkg::p2g_cfg_type        cfg,
   p2g_req_if.sink                     req,
   output logic                        out_valid,
   output logic [p2g_pkg::ANG_W-1:0]   out_angle,
   output logic signed [OFS_BITS-1:0]  out_dx,
   input  logic                        out_ready
);
   import p2g_pkg::*;

   localparam int N = ANGLE_ITERATIONS;
   localparam int LAST = N + 1;
   localparam int VW = ((OFS_BITS > 16) ? OFS_BITS : 16) + 19;

   logic                       v_ff  [0:LAST];
   logic signed [VW-1:0]       vx_ff [0:N];
   logic signed [VW-1:0]       vy_ff [0:N];
   logic [ANG_W-1:0]           vz_ff [0:N];
   logic signed [OFS_BITS-1:0] dx_ff [0:LAST];
   logic [ANG_W-1:0]           ang_ff;

   logic                       en;
   logic [14:0]                f2;
   logic signed [OFS_BITS-1:0] dx;
   logic signed [OFS_BITS-1:0] dy;
   logic signed [VW-1:0]       dy_ext;

   // Pitch conversion follows the register; it is settled long before use.
   logic [15:0]      pmag;
   logic [29:0]      pnum;
   logic [60:0]      pprod_ff;
   logic             pneg_ff;
   logic [ANG_W-1:0] pitch_u_ff;
   logic [ANG_W-1:0] pq;

   assign en        = !v_ff[LAST] || out_ready;
   assign req.ready = en;

   assign f2     = (cfg.focal_length_px == '0) ? 15'd2 : {cfg.focal_length_px, 1'b0};
   assign dx     = $signed(OFS_BITS'({req.pixel_x, 1'b0})) -
                   $signed(OFS_BITS'(cfg.image_width));
   assign dy     = $signed(OFS_BITS'({req.pixel_y, 1'b0})) -
                   $signed(OFS_BITS'(cfg.image_height));
   assign dy_ext = VW'(dy);

   assign pmag = cfg.pitch_angle[15] ? 16'(-cfg.pitch_angle) : cfg.pitch_angle;
   assign pnum = {pmag, 14'd0} + PITCH_BIAS;
   assign pq   = pprod_ff[PITCH_SHIFT+ANG_W-1:PITCH_SHIFT];

   always_ff @(posedge clock) begin
      pprod_ff   <= 61'(pnum) * 61'(PITCH_RECIP);
      pneg_ff    <= cfg.pitch_angle[15];
      pitch_u_ff <= pneg_ff ? ANG_W'(-pq) : pq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req.valid;
         for (int s = 1; s <= LAST; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0] <= $signed(VW'({f2, 16'd0}));
         vy_ff[0] <= dy_ext <<< 16;
         vz_ff[0] <= '0;
         dx_ff[0] <= dx;
         ang_ff   <= pitch_u_ff + vz_ff[N];
         dx_ff[LAST] <= dx_ff[N];
      end
   end

   // Vectoring rotations drive y toward zero and collect the angle.
   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (en) begin
            if (!vy_ff[i][VW-1]) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + atan_step(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - atan_step(i);
            end
            dx_ff[i+1] <= dx_ff[i];
         end
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_angle = ang_ff;
   assign out_dx    = dx_ff[LAST];

endmodule

// ===== design/p2g_queue.sv =====
// ----------------------------------------------------------------------------
// p2g_queue
// Short queue between the angle front end and the projection back end.
// ----------------------------------------------------------------------------
module p2g_queue #(
   parameter int W = 39
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         in_space,
   output logic         head_valid,
   output logic [W-1:0] head_data,
   input  logic         pull
);
   import p2g_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [W-1:0]  mem_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] rd_ff;
   logic [PW:0]   count_ff;
   logic          push;
   logic          pop;

   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ff];
   assign pop        = pull && head_valid;
   assign in_space   = (count_ff != (PW+1)'(QUEUE_DEPTH)) || pop;
   assign push       = in_valid && in_space;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule

// ===== design/p2g_back.sv =====
// ----------------------------------------------------------------------------
// p2g_back
// Turns the total angle into tangents and ground distances, with clamping.
// ----------------------------------------------------------------------------
module p2g_back #(
   parameter int ANGLE_ITERATIONS = 16,
   parameter int OFS_BITS = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  p2g_pkg::p2g_cfg_type        cfg,
   input  logic                        head_valid,
   input  logic [p2g_pkg::ANG_W-1:0]   head_angle,
   input  logic signed [OFS_BITS-1:0]  head_dx,
   output logic                        pull,
   p2g_rsp_if.source                   rsp
);
   import p2g_pkg::*;

   localparam int N = ANGLE_ITERATIONS;
   localparam int RW = 33;
   localparam int NBV = RW + 17;
   localparam int NBH = OFS_BITS + 17;
   localparam logic signed [RW-1:0] UNIT_X = RW'(64'h4000_0000);
   localparam logic signed [48:0] F_HI = 49'sh7FFF_FFFF;
   localparam logic signed [48:0] F_LO = -49'sh8000_0000;
   localparam logic signed [63:0] L_HI = 64'sh7FFF_FFFF;
   localparam logic signed [63:0] L_LO = -64'sh8000_0000;

   logic                       en;
   logic                       rv_ff [0:N];
   logic signed [RW-1:0]       rx_ff [0:N];
   logic signed [RW-1:0]       ry_ff [0:N];
   logic signed [ROT_Z_W-1:0]  rz_ff [0:N];
   logic signed [OFS_BITS-1:0] rdx_ff [0:N];

   assign en   = !rsp.valid || rsp.ready;
   assign pull = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= N; s++) rv_ff[s] <= 1'b0;
      end else if (en) begin
         rv_ff[0] <= head_valid;
         for (int s = 1; s <= N; s++) rv_ff[s] <= rv_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]  <= UNIT_X;
         ry_ff[0]  <= '0;
         rz_ff[0]  <= ROT_Z_W'($signed(head_angle));
         rdx_ff[0] <= head_dx;
      end
   end

   // Rotation from the unit vector by the total angle gives cosine and sine.
   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (en) begin
            if (!rz_ff[i][ROT_Z_W-1]) begin
               rx_ff[i+1] <= rx_ff[i] - (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] + (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] - $signed(ROT_Z_W'(atan_step(i)));
            end else begin
               rx_ff[i+1] <= rx_ff[i] + (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] - (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] + $signed(ROT_Z_W'(atan_step(i)));
            end
            rdx_ff[i+1] <= rdx_ff[i];
         end
      end
   end

   // Rounded quotient setup: magnitude * 2^16 plus half the divisor.
   logic                 nonpos;
   logic [RW-1:0]        ymag;
   logic [NBV-1:0]       num_v;
   logic [RW-1:0]        den_v;
   logic [14:0]          f2;
   logic [OFS_BITS-1:0]  dxmag;
   logic [NBH-1:0]       num_h;

   assign nonpos = rx_ff[N][RW-1] || (rx_ff[N] == '0);
   assign ymag   = ry_ff[N][RW-1] ? RW'(-ry_ff[N]) : RW'(ry_ff[N]);
   assign num_v  = NBV'({ymag, 16'd0}) + NBV'(rx_ff[N][RW-1:1]);
   assign den_v  = nonpos ? RW'(1) : RW'(rx_ff[N]);
   assign f2     = (cfg.focal_length_px == '0) ? 15'd2 : {cfg.focal_length_px, 1'b0};
   assign dxmag  = rdx_ff[N][OFS_BITS-1] ? OFS_BITS'(-rdx_ff[N]) : OFS_BITS'(rdx_ff[N]);
   assign num_h  = NBH'({dxmag, 16'd0}) + NBH'(f2[14:1]);

   logic                dv_valid;
   logic [QUO_BITS-1:0] q_v;
   logic                ovf_v;
   logic [1:0]          side_v;
   logic                dh_valid;
   logic [QUO_BITS-1:0] q_h;
   logic                ovf_h;
   logic                neg_h;

   p2g_divider #(.NB(NBV), .DB(RW), .SW(2)) u_div_v (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rv_ff[N]),
      .num       (num_v),
      .den       (den_v),
      .side_in   ({ry_ff[N][RW-1], nonpos}),
      .out_valid (dv_valid),
      .quo       (q_v),
      .ovf       (ovf_v),
      .side_out  (side_v)
   );

   p2g_divider #(.NB(NBH), .DB(15), .SW(1)) u_div_h (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rv_ff[N]),
      .num       (num_h),
      .den       (f2),
      .side_in   (rdx_ff[N][OFS_BITS-1]),
      .out_valid (dh_valid),
      .quo       (q_h),
      .ovf       (ovf_h),
      .side_out  (neg_h)
   );

   // Signed, clamped tangents.
   logic signed [TAN_W-1:0] mag_v;
   logic signed [TAN_W-1:0] mag_h;
   logic signed [TAN_W-1:0] tanv_in;
   logic signed [TAN_W-1:0] tanh_in;

   always_comb begin
      mag_v   = (side_v[0] || ovf_v) ? TAN_MAX : $signed({1'b0, q_v});
      mag_h   = ovf_h ? TAN_MAX : $signed({1'b0, q_h});
      tanv_in = side_v[1] ? -mag_v : mag_v;
      tanh_in = neg_h ? -mag_h : mag_h;
   end

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [TAN_W-1:0] tanv1_ff;
   logic signed [TAN_W-1:0] tanh1_ff, tanh2_ff, tanh3_ff;
   logic                    sat1_ff, sat2_ff, sat3_ff, sat4_ff, sat5_ff;
   logic signed [48:0]      pf2_ff;
   logic signed [31:0]      fwd3_ff, fwd4_ff, fwd5_ff;
   logic signed [63:0]      pl4_ff;
   logic signed [31:0]      lat5_ff;

   logic signed [48:0] fsh;
   logic signed [31:0] fwd_in;
   logic               fclip;
   logic signed [63:0] lsh;
   logic signed [31:0] lat_in;
   logic               lclip;

   always_comb begin
      fsh    = (pf2_ff + 49'sd32768) >>> 16;
      fclip  = (fsh > F_HI) || (fsh < F_LO);
      fwd_in = (fsh > F_HI) ? 32'sh7FFF_FFFF :
               (fsh < F_LO) ? 32'sh8000_0000 : fsh[31:0];
      lsh    = (pl4_ff + 64'sd32768) >>> 16;
      lclip  = (lsh > L_HI) || (lsh < L_LO);
      lat_in = (lsh > L_HI) ? 32'sh7FFF_FFFF :
               (lsh < L_LO) ? 32'sh8000_0000 : lsh[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= dv_valid && dh_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tanv1_ff <= tanv_in;
         tanh1_ff <= tanh_in;
         sat1_ff  <= side_v[0] || ovf_v || ovf_h;

         pf2_ff   <= 49'($signed({1'b0, cfg.camera_height_mm})) * 49'(tanv1_ff);
         tanh2_ff <= tanh1_ff;
         sat2_ff  <= sat1_ff;

         fwd3_ff  <= fwd_in;
         tanh3_ff <= tanh2_ff;
         sat3_ff  <= sat2_ff || fclip;

         pl4_ff   <= 64'(fwd3_ff) * 64'(tanh3_ff);
         fwd4_ff  <= fwd3_ff;
         sat4_ff  <= sat3_ff;

         fwd5_ff  <= fwd4_ff;
         lat5_ff  <= lat_in;
         sat5_ff  <= sat4_ff || lclip;
      end
   end

   assign rsp.valid      = v5_ff;
   assign rsp.forward_mm = fwd5_ff;
   assign rsp.lateral_mm = lat5_ff;
   assign rsp.saturated  = sat5_ff;

endmodule

// ===== design/p2g_checker.sv =====
// ----------------------------------------------------------------------------
// p2g_checker
// Port-level checks on the result channel of the ground position unit.
// ----------------------------------------------------------------------------
`include "pixel_to_ground_position_unit_assert.svh"

module p2g_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_forward_mm,
   input logic [31:0] rsp_lateral_mm,
   input logic        rsp_saturated
);

   // A result word never survives reset.
   `P2G_ASSERT_RAW(a_reset_clears, reset, !rsp_valid)
   // Zero forward distance without clamping projects to zero lateral offset.
   `P2G_ASSERT_NOW(a_zero_forward, rsp_valid && !rsp_saturated && rsp_forward_mm == '0, rsp_lateral_mm == '0)
   `P2G_ASSERT_NEXT(a_valid_holds, rsp_valid && !rsp_ready, rsp_valid)
   `P2G_ASSERT_NEXT(a_word_stable, rsp_valid && !rsp_ready, $stable(rsp_forward_mm) && $stable(rsp_lateral_mm) && $stable(rsp_saturated))

endmodule

bind pixel_to_ground_position_unit p2g_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_forward_mm (rsp.forward_mm),
   .rsp_lateral_mm (rsp.lateral_mm),
   .rsp_saturated  (rsp.saturated)
);
